@@ src/chs_pkg.sv @@
// ---------------------------------------------------------------------------
// chs_pkg: shared types and constants for the chained hash set
// Status codes, controller states and the command/status structs that join
// the controller and the datapath.
// ---------------------------------------------------------------------------
package chs_pkg;

  localparam int BUCKETS_DEF    = 64;
  localparam int POOL_NODES_DEF = 256;
  localparam int KEY_W          = 31;
  localparam int TS_W           = 7;
  localparam int STATUS_W       = 2;
  localparam int BUCKET_OUT_W   = 6;
  localparam int NODE_OUT_W     = 8;
  localparam int TS_RESET       = 64;

  localparam logic [STATUS_W-1:0] ST_PRESENT  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_HEAD,
    S_READ,
    S_CMP,
    S_INS,
    S_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture request, start reduction
    logic div_step;   // one restoring-subtract step
    logic head_rd;    // latch bucket head as walk pointer
    logic node_rd;    // issue pool read at pointer
    logic advance;    // follow link
    logic insert;     // write node and head, bump allocator
    logic set_hit;
    logic set_absent;
    logic set_full;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic ptr_null;
    logic key_eq;
    logic steps_out;
    logic is_insert;
    logic pool_full;
  } stat_t;

endpackage

@@ src/chs_ctrl.sv @@
// ---------------------------------------------------------------------------
// chs_ctrl: sequencer for the chained hash set
// Steps each request through reduction, head fetch, chain walk and result.
// ---------------------------------------------------------------------------
module chs_ctrl
  import chs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t state, state_next;

  // hold state
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // sequence the walk
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (st.div_done) state_next = S_HEAD;
        else cmd.div_step = 1'b1;
      end
      S_HEAD: begin
        cmd.head_rd = 1'b1;
        state_next  = S_READ;
      end
      S_READ: begin
        if (st.ptr_null || st.steps_out) begin
          state_next = S_INS;
        end else begin
          cmd.node_rd = 1'b1;
          state_next  = S_CMP;
        end
      end
      S_CMP: begin
        if (st.key_eq) begin
          cmd.set_hit = 1'b1;
          state_next  = S_OUT;
        end else begin
          cmd.advance = 1'b1;
          state_next  = S_READ;
        end
      end
      S_INS: begin
        if (!st.is_insert) cmd.set_absent = 1'b1;
        else if (st.pool_full) cmd.set_full = 1'b1;
        else cmd.insert = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ src/chs_dp.sv @@
// ---------------------------------------------------------------------------
// chs_dp: datapath for the chained hash set
// Bucket reduction by shift-subtract, bucket head table, node pool memory,
// walk pointer and allocator.
// ---------------------------------------------------------------------------
module chs_dp
  import chs_pkg::*;
#(
  parameter int BUCKETS    = BUCKETS_DEF,
  parameter int POOL_NODES = POOL_NODES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    table_size_we,
  input  logic [TS_W-1:0]         table_size,
  input  logic                    opcode,
  input  logic [KEY_W-1:0]        key,
  input  cmd_t                    cmd,
  output stat_t                   st,
  output logic [STATUS_W-1:0]     status,
  output logic [BUCKET_OUT_W-1:0] bucket,
  output logic [NODE_OUT_W-1:0]   node
);

  localparam int BW    = $clog2(BUCKETS);
  localparam int BCW   = $clog2(BUCKETS + 1);
  localparam int NW    = $clog2(POOL_NODES);
  localparam int PW    = NW + 1;                 // pointer incl. null marker
  localparam int DIVW  = (TS_W > BCW) ? TS_W : BCW;
  localparam int CNTW  = $clog2(KEY_W + 1);
  localparam logic [PW-1:0] NULL_P = PW'(POOL_NODES);

  // configured size
  logic [TS_W-1:0] ts_reg;
  always_ff @(posedge clk) begin
    if (rst) ts_reg <= TS_W'(TS_RESET);
    else if (table_size_we) ts_reg <= table_size;
  end

  // clamp to 1..BUCKETS
  logic [DIVW-1:0] eff;
  always_comb begin
    if (ts_reg == '0) eff = DIVW'(1);
    else if (DIVW'(ts_reg) > DIVW'(BUCKETS)) eff = DIVW'(BUCKETS);
    else eff = DIVW'(ts_reg);
  end

  // request capture and restoring remainder, one key bit a step
  logic              op_r;
  logic [KEY_W-1:0]  key_r, shf;
  logic [DIVW:0]     rem;
  logic [DIVW-1:0]   div_r;
  logic [CNTW-1:0]   cnt;
  logic [DIVW:0]     trial;
  assign trial = {rem[DIVW-1:0], shf[KEY_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= opcode;
      key_r <= key;
      shf   <= key;
      rem   <= '0;
      div_r <= eff;
      cnt   <= CNTW'(KEY_W);
    end else if (cmd.div_step) begin
      shf <= shf << 1;
      cnt <= cnt - 1'b1;
      if (trial >= {1'b0, div_r}) rem <= trial - {1'b0, div_r};
      else rem <= trial;
    end
  end
  logic [BW-1:0] bkt;
  assign bkt = rem[BW-1:0];

  // bucket heads: valid bit per entry, empty reads as null
  logic [PW-1:0]  heads [BUCKETS];
  logic [BUCKETS-1:0] hvalid;
  logic [PW-1:0]  head_r;

  // node pool memory
  logic [KEY_W-1:0] mem_key  [POOL_NODES];
  logic [PW-1:0]    mem_link [POOL_NODES];
  logic [KEY_W-1:0] rd_key;
  logic [PW-1:0]    rd_link;

  logic [PW-1:0]    ptr;
  logic [PW-1:0]    steps;
  logic [PW-1:0]    free_cnt;

  // head table and allocator
  always_ff @(posedge clk) begin
    if (rst) begin
      hvalid   <= '0;
      free_cnt <= '0;
    end else if (cmd.insert) begin
      hvalid[bkt] <= 1'b1;
      free_cnt    <= free_cnt + 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.insert) heads[bkt] <= free_cnt;
  end

  // pool write and registered read
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      mem_key[free_cnt[NW-1:0]]  <= key_r;
      mem_link[free_cnt[NW-1:0]] <= head_r;
    end
    if (cmd.node_rd) begin
      rd_key  <= mem_key[ptr[NW-1:0]];
      rd_link <= mem_link[ptr[NW-1:0]];
    end
  end

  // walk pointer; latch the bucket head for the walk and for a later insert
  always_ff @(posedge clk) begin
    if (cmd.head_rd) begin
      ptr    <= hvalid[bkt] ? heads[bkt] : NULL_P;
      head_r <= hvalid[bkt] ? heads[bkt] : NULL_P;
      steps  <= '0;
    end else if (cmd.advance) begin
      ptr   <= rd_link;
      steps <= steps + 1'b1;
    end
  end

  // result
  always_ff @(posedge clk) begin
    if (cmd.set_hit) begin
      status <= ST_PRESENT;
      node   <= NODE_OUT_W'(ptr);
    end else if (cmd.set_absent) begin
      status <= ST_ABSENT;
      node   <= '0;
    end else if (cmd.set_full) begin
      status <= ST_FULL;
      node   <= '0;
    end else if (cmd.insert) begin
      status <= ST_INSERTED;
      node   <= NODE_OUT_W'(free_cnt);
    end
  end
  assign bucket = BUCKET_OUT_W'(rem);

  assign st.div_done  = (cnt == '0);
  assign st.ptr_null  = (ptr >= NULL_P);
  assign st.key_eq    = (rd_key == key_r);
  assign st.steps_out = (steps >= NULL_P);
  assign st.is_insert = (op_r == OP_INSERT);
  assign st.pool_full = (free_cnt >= NULL_P);

endmodule

@@ src/chained_hash_set.sv @@
// ---------------------------------------------------------------------------
// chained_hash_set: hash set of integer keys with separate chaining
// Lookup or insert-if-absent of one key per request over a node pool.
// ---------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+----------------------
//  in       | in_valid / in_ready   | opcode, key
//  out      | out_valid / out_ready | status, bucket, node
//  config   | table_size_we         | table_size
//
// A request's time is set by the 31-step key reduction and the one-read-per-node
// pool port, grows with the chain nodes read, is longer on a miss than on a hit,
// and adds any output wait.
// One request at a time; the result holds until out_ready.
// Reset clears the head table at once through per-bucket valid bits.
// ---------------------------------------------------------------------------
module chained_hash_set
  import chs_pkg::*;
#(
  parameter int BUCKETS    = BUCKETS_DEF,
  parameter int POOL_NODES = POOL_NODES_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    table_size_we,
  input  logic [TS_W-1:0]         table_size,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    opcode,
  input  logic [KEY_W-1:0]        key,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [STATUS_W-1:0]     status,
  output logic [BUCKET_OUT_W-1:0] bucket,
  output logic [NODE_OUT_W-1:0]   node
);

  cmd_t  cmd;
  stat_t st;

  chs_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .st, .cmd
  );

  chs_dp #(.BUCKETS(BUCKETS), .POOL_NODES(POOL_NODES)) u_dp (
    .clk, .rst, .table_size_we, .table_size, .opcode, .key, .cmd, .st,
    .status, .bucket, .node
  );

endmodule

@@ verif/chs_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// chs_checker: lookup/insert predictor and result checker
// Watches the request and result channels of the chained hash set, keeps
// its own copy of the table, computes the expected status, bucket and node
// for each accepted request, and compares results in order.
// ---------------------------------------------------------------------------
module chs_checker
  import chs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    table_size_we,
  input  logic [TS_W-1:0]         table_size,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic                    opcode,
  input  logic [KEY_W-1:0]        key,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic [STATUS_W-1:0]     status,
  input  logic [BUCKET_OUT_W-1:0] bucket,
  input  logic [NODE_OUT_W-1:0]   node,
  output int                      fail_count,
  output int                      pending,
  output int                      result_count
);

  localparam int NULL_NODE = POOL_NODES_DEF;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic [BUCKET_OUT_W-1:0] bucket;
    logic [NODE_OUT_W-1:0]   node;
  } chs_result_t;

  chs_result_t expected_results[$];
  logic [TS_W-1:0] modulus_reg;
  int heads[BUCKETS_DEF];
  logic [KEY_W-1:0] keys[POOL_NODES_DEF];
  int links[POOL_NODES_DEF];
  int nodes_used;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // Compute one lookup/insert and update the shadow table.
  function automatic chs_result_t hash_access(input logic op, input logic [KEY_W-1:0] k);
    chs_result_t r;
    int m, b, p, steps, hit;
    m = (modulus_reg == 0) ? 1 : (modulus_reg > BUCKETS_DEF ? BUCKETS_DEF : modulus_reg);
    b = k % m;
    p = heads[b];
    steps = 0;
    hit = NULL_NODE;
    while (p < POOL_NODES_DEF && steps < POOL_NODES_DEF) begin
      if (keys[p] == k) begin
        hit = p;
        break;
      end
      p = links[p];
      steps++;
    end
    r.bucket = b[BUCKET_OUT_W-1:0];
    r.node = '0;
    if (hit != NULL_NODE) begin
      r.status = ST_PRESENT;
      r.node = hit[NODE_OUT_W-1:0];
    end else if (op == OP_LOOKUP) begin
      r.status = ST_ABSENT;
    end else if (nodes_used >= POOL_NODES_DEF) begin
      r.status = ST_FULL;
    end else begin
      keys[nodes_used] = k;
      links[nodes_used] = heads[b];
      heads[b] = nodes_used;
      r.status = ST_INSERTED;
      r.node = nodes_used[NODE_OUT_W-1:0];
      nodes_used++;
    end
    return r;
  endfunction

  // Track config, predict on accept, compare on result.
  always @(posedge clk) begin
    chs_result_t want;
    if (rst) begin
      modulus_reg <= TS_W'(TS_RESET);
      for (int i = 0; i < BUCKETS_DEF; i++) heads[i] = NULL_NODE;
      nodes_used = 0;
      expected_results.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (out_valid && out_ready) begin
        result_count++;
        if (expected_results.size() == 0) begin
          report_mismatch("result count", result_count, result_count - 1);
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status) report_mismatch("status", status, want.status);
          if (bucket !== want.bucket) report_mismatch("bucket", bucket, want.bucket);
          if (node !== want.node) report_mismatch("node", node, want.node);
        end
      end
      if (in_valid && in_ready) expected_results.push_back(hash_access(opcode, key));
      if (table_size_we) modulus_reg <= table_size;
    end
    pending = expected_results.size();
  end

endmodule

@@ verif/tb_chained_hash_set.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_chained_hash_set: stimulus and verdict for the chained hash set
// Drives lookups and inserts over several table sizes and idle patterns,
// fills the pool to exhaustion, and lets the checker judge every result.
// ---------------------------------------------------------------------------
module tb_chained_hash_set
  import chs_pkg::*;
;

  logic                    clk;
  logic                    rst;
  logic                    table_size_we;
  logic [TS_W-1:0]         table_size;
  logic                    in_valid;
  logic                    in_ready;
  logic                    opcode;
  logic [KEY_W-1:0]        key;
  logic                    out_valid;
  logic                    out_ready;
  logic [STATUS_W-1:0]     status;
  logic [BUCKET_OUT_W-1:0] bucket;
  logic [NODE_OUT_W-1:0]   node;
  int fail_count, pending, result_count;
  int send_idle_pct, stall_pct;
  int sent;
  logic [KEY_W-1:0] key_pool[$];

  chained_hash_set dut (
    .clk(clk), .rst(rst), .table_size_we(table_size_we), .table_size(table_size),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .key(key),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .bucket(bucket), .node(node)
  );

  chs_checker u_checker (
    .clk(clk), .rst(rst), .table_size_we(table_size_we), .table_size(table_size),
    .in_valid(in_valid), .in_ready(in_ready), .opcode(opcode), .key(key),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .bucket(bucket), .node(node), .fail_count(fail_count), .pending(pending),
    .result_count(result_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop.
  initial begin
    #20000000;
    $display("timeout");
    $display("chained_hash_set verification failed");
    $finish;
  end

  // Randomly stall the result side.
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Send one request, with random idle cycles ahead of it; valid drops only
  // when idling or draining.
  task automatic send_request(input logic op, input logic [KEY_W-1:0] k);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    key <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  // Drop valid, wait for all results, then for the block to settle.
  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_size(input logic [TS_W-1:0] v);
    table_size <= v;
    table_size_we <= 1'b1;
    @(negedge clk);
    table_size_we <= 1'b0;
  endtask

  // Mostly keys seen before, some fresh; favor small keys for collisions.
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (key_pool.size() != 0 && r < 55) return key_pool[$urandom_range(key_pool.size() - 1)];
    if (r < 80) return KEY_W'($urandom_range(300));
    return KEY_W'($urandom());
  endfunction

  task automatic random_phase(input int count, input int idle, input int stall);
    logic [KEY_W-1:0] k;
    logic op;
    send_idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      k = pick_key();
      op = 1'($urandom_range(1));
      if (op == OP_INSERT) key_pool.push_back(k);
      send_request(op, k);
    end
  endtask

  initial begin
    rst = 1'b1;
    table_size_we = 1'b0;
    table_size = '0;
    in_valid = 1'b0;
    opcode = OP_LOOKUP;
    key = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    sent = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: key extremes at reset size, repeats, then clamp cases.
    send_request(OP_LOOKUP, 31'h7fffffff);
    send_request(OP_INSERT, 31'h7fffffff);
    send_request(OP_INSERT, 31'd0);
    send_request(OP_INSERT, 31'd64);
    send_request(OP_INSERT, 31'd128);
    send_request(OP_LOOKUP, 31'd64);
    send_request(OP_LOOKUP, 31'd0);
    send_request(OP_INSERT, 31'd128);
    send_request(OP_LOOKUP, 31'h2aaaaaaa);
    send_request(OP_INSERT, 31'h55555555);
    drain();
    write_size(7'd0);
    send_request(OP_LOOKUP, 31'd64);
    send_request(OP_INSERT, 31'd5);
    drain();
    write_size(7'd127);
    send_request(OP_LOOKUP, 31'd128);
    send_request(OP_LOOKUP, 31'd5);
    drain();
    write_size(7'd1);
    send_request(OP_INSERT, 31'd0);
    send_request(OP_LOOKUP, 31'h7fffffff);
    drain();
    write_size(7'd7);
    send_request(OP_INSERT, 31'd64);
    send_request(OP_LOOKUP, 31'd6);
    drain();

    // Random phases over sizes and idle patterns.
    write_size(7'd64);
    random_phase(150, 0, 0);
    drain();
    write_size(7'd3);
    random_phase(150, 58, 0);
    drain();
    write_size(7'd65);
    random_phase(150, 0, 58);
    drain();
    write_size(7'd1);
    random_phase(100, 38, 38);
    drain();
    write_size(7'd64);
    random_phase(100, 0, 0);
    // Pool is exhausted by now; keep hitting refused inserts.
    drain();
    write_size(7'd17);
    random_phase(500, 38, 38);
    drain();
    write_size(7'd64);
    random_phase(500, 0, 0);
    random_phase(280, 58, 58);
    drain();

    $display("Sent %0d requests, checked %0d results over table sizes 0..127,", sent,
             result_count);
    $display("including pool exhaustion and idle/stall patterns.");
    if (fail_count == 0) begin
      $display("chained_hash_set verification clean");
    end else begin
      $display("chained_hash_set verification failed");
    end
    $finish;
  end

endmodule
